// File: hdl/lgs_pkg.sv
package lgs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // row address into the cell store, and a row count that can hold the height itself
    localparam int ROW_AW = $clog2(MAX_HEIGHT);
    localparam int ROW_CW = $clog2(MAX_HEIGHT + 1);

    // fixed field and register widths
    localparam int CFG_W   = 7;
    localparam int COL_W   = 6;
    localparam int ROWF_W  = 6;
    localparam int ACT_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_STEP   = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    // register index taken from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACC  = 6'b000010,
        ST_ACC2 = 6'b000100,
        ST_FILL = 6'b001000,
        ST_RUN  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

// File: hdl/life_grid_generation_step_top.sv
// Conway life grid, rule B3/S23, on up to 64 x 64 one-bit cells.
//
// Input stream (s_*): one transaction per command: write a cell, read a
// cell, or advance the grid by one generation. Output stream (m_*): exactly
// one transaction per command, carrying status (1 = position outside the
// configured grid) and cell_alive (read result, else 0).
// APB port: register 0 grid_width, register 1 grid_height (7 bits each,
// values above 64 act as 64). Write only while the block is idle.
//
// Timing: a cell write or read goes from acceptance to the result register
// through a read of the row, then modify or pick the bit, then the result
// hand-off. A generation step sweeps every row of the grid (an empty grid
// stops after the first row read is issued): the row store has one read and
// one write port, and the sweep reads one row and writes back one updated
// row per cycle through a three-row window. s_tready is low from acceptance
// until the result is loaded into the output register; the next command may
// then be accepted while that result still waits on m_tready.
// A stalled receiver holds the result; a further result waits in the block.
// Reset: both registers return to 64 and all cells read as dead at once
// (per-row valid bits), no clearing pass.
module life_grid_generation_step_top
    import lgs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] action, [7:2] column, [13:8] row, [14] cell_value, [15] zero
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] status, [1] cell_alive, [7:2] zero
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // cell store and per-row valid bits
    row_t                  mem [MAX_HEIGHT];
    row_t                  rdata_reg;
    logic [MAX_HEIGHT-1:0] row_valid_reg;
    logic                  rd_live_reg;

    // configuration
    logic [CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [CFG_W-1:0] w_eff, h_eff;

    // sequencer
    state_t            state_reg, state_next;
    action_t           act_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROWF_W-1:0] row_reg;
    logic              val_reg;
    logic [ROW_CW-1:0] issue_reg, issue_next;
    logic [ROW_CW-1:0] wr_reg, wr_next;
    logic              prime_reg, prime_next;
    row_t              prev_reg, prev_next, cur_reg, cur_next;
    logic              res_status_reg, res_status_next;
    logic              res_alive_reg, res_alive_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_alive_reg;

    // derived
    row_t              col_mask, incoming, new_row, wr_data;
    logic              in_acc, out_free, load_out, out_range, mem_we, rd_live;
    logic [ROW_CW-1:0] rd_addr;
    logic [ROW_AW-1:0] wr_addr;

    assign w_eff = (grid_width_reg  > CFG_W'(MAX_WIDTH))  ? CFG_W'(MAX_WIDTH)  : grid_width_reg;
    assign h_eff = (grid_height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : grid_height_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            col_mask[i] = (CFG_W'(i) < w_eff);
        end
    end

    // ---------------- APB ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(MAX_WIDTH);
            grid_height_reg <= CFG_W'(MAX_HEIGHT);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_GRID_WIDTH)
            begin
                grid_width_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                grid_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GRID_WIDTH) ? PDATA_W'(grid_width_reg)
                                                 : PDATA_W'(grid_height_reg);

    // ---------------- handshakes ----------------
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-2){1'b0}}, out_alive_reg, out_status_reg};

    // ---------------- row store ----------------
    // read address: sweep row during a step, else the addressed row
    assign rd_addr = (state_reg == ST_FILL || state_reg == ST_RUN) ? issue_reg
                                                                  : ROW_CW'(row_reg);
    assign rd_live = (rd_addr < ROW_CW'(h_eff)) && row_valid_reg[rd_addr[ROW_AW-1:0]];

    assign out_range = (CFG_W'(col_reg) >= w_eff) || (CFG_W'(row_reg) >= h_eff);
    assign incoming  = rd_live_reg ? rdata_reg : '0;

    lgs_row_unit u_row
    (
        .above   (prev_reg & col_mask),
        .mid     (cur_reg & col_mask),
        .below   (incoming & col_mask),
        .mid_raw (cur_reg),
        .col_mask(col_mask),
        .new_row (new_row)
    );

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = wr_reg[ROW_AW-1:0];
        wr_data = new_row;
        if (state_reg == ST_RUN && !prime_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_ACC2 && act_reg == ACT_WRITE && !out_range)
        begin
            mem_we  = 1'b1;
            wr_addr = row_reg[ROW_AW-1:0];
            wr_data = incoming;
            wr_data[col_reg] = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr[ROW_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= rd_live;
            if (mem_we)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        wr_next         = wr_reg;
        prime_next      = prime_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_alive_next  = res_alive_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_status_next = 1'b0;
                    res_alive_next  = 1'b0;
                    issue_next      = '0;
                    wr_next         = '0;
                    priority if (action_t'(s_tdata[1:0]) == ACT_STEP)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (action_t'(s_tdata[1:0]) == ACT_UNUSED)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC:
            begin
                state_next = ST_ACC2;   // row read issued
            end
            ST_ACC2:
            begin
                res_status_next = out_range;
                res_alive_next  = !out_range && (act_reg == ACT_READ) && incoming[col_reg];
                state_next      = ST_DONE;
            end
            ST_FILL:
            begin
                // row 0 read issued; nothing to do on an empty grid
                issue_next = issue_reg + 1'b1;
                prime_next = 1'b1;
                prev_next  = '0;
                state_next = (h_eff == '0) ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                issue_next = issue_reg + 1'b1;
                if (prime_reg)
                begin
                    prime_next = 1'b0;
                    cur_next   = incoming;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = incoming;
                    wr_next   = wr_reg + 1'b1;
                    if (CFG_W'(wr_reg) + 1'b1 == h_eff)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            issue_reg     <= '0;
            wr_reg        <= '0;
            prime_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            issue_reg     <= issue_next;
            wr_reg        <= wr_next;
            prime_reg     <= prime_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg <= action_t'(s_tdata[1:0]);
            col_reg <= s_tdata[7:2];
            row_reg <= s_tdata[13:8];
            val_reg <= s_tdata[14];
        end
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_alive_reg  <= res_alive_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_alive_reg  <= res_alive_reg;
        end
    end

endmodule

// File: hdl/lgs_row_unit.sv
module lgs_row_unit
    import lgs_pkg::*;
(
    input  row_t above,     // masked: dead outside the grid
    input  row_t mid,       // masked
    input  row_t below,     // masked
    input  row_t mid_raw,   // stored row, keeps columns beyond the grid
    input  row_t col_mask,
    output row_t new_row
);

    row_t       gen;
    logic [3:0] cnt [MAX_WIDTH];
    logic       a_l, a_r, m_l, m_r, b_l, b_r;

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            a_l = (i > 0) ? above[(i > 0) ? i - 1 : 0] : 1'b0;
            m_l = (i > 0) ? mid[(i > 0) ? i - 1 : 0] : 1'b0;
            b_l = (i > 0) ? below[(i > 0) ? i - 1 : 0] : 1'b0;
            a_r = (i < MAX_WIDTH - 1) ? above[(i < MAX_WIDTH - 1) ? i + 1 : i] : 1'b0;
            m_r = (i < MAX_WIDTH - 1) ? mid[(i < MAX_WIDTH - 1) ? i + 1 : i] : 1'b0;
            b_r = (i < MAX_WIDTH - 1) ? below[(i < MAX_WIDTH - 1) ? i + 1 : i] : 1'b0;
            cnt[i] = {3'b000, a_l} + {3'b000, above[i]} + {3'b000, a_r}
                   + {3'b000, m_l} + {3'b000, m_r}
                   + {3'b000, b_l} + {3'b000, below[i]} + {3'b000, b_r};
            // B3/S23
            gen[i] = (cnt[i] == 4'd3) || (mid[i] && (cnt[i] == 4'd2));
        end
    end

    assign new_row = (gen & col_mask) | (mid_raw & ~col_mask);

endmodule

// File: hdl/lgs_checker.sv
module lgs_checker
    import lgs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    // one command at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");

    // an out-of-range access never reports a live cell
    a_range_dead: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[1])
        else $error("live cell reported with out-of-range status");

    // padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_DATA_W-1:2] == '0))
        else $error("nonzero padding in output");

endmodule

bind life_grid_generation_step_top lgs_checker u_lgs_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// File: bench/tb_life_grid_generation_step_top.sv
`timescale 1ns / 1ps

module tb_life_grid_generation_step_top;
    import lgs_pkg::*;

    // no-progress cycles before the run is declared hung; it covers a generation
    // step on the full grid plus the longest stall on both sides
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 16;
    localparam int PHASE_ITEMS    = 114;
    localparam int CALM_PHASES    = 2;

    typedef struct packed {
        logic               cell_value;
        logic [ROWF_W-1:0]  row;
        logic [COL_W-1:0]   column;
        action_t            action;
    } life_cmd_t;

    typedef struct {
        logic status;
        logic cell_alive;
    } life_resp_t;

    // Grid predictor plus the queue of responses still owed by the block.
    class life_grid_model;
        row_t             cells [MAX_HEIGHT];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        life_resp_t       awaited [$];
        int               mismatches;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            width_reg  = 7'd64;
            height_reg = 7'd64;
            mismatches = 0;
        endfunction

        function int used_width();
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        endfunction

        function int used_height();
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_register(logic reg_sel, logic [PDATA_W-1:0] word);
            if (reg_sel == REG_GRID_WIDTH)
                width_reg = word[CFG_W-1:0];
            else
                height_reg = word[CFG_W-1:0];
        endfunction

        // B3/S23 over the grid in use, from a snapshot; cells outside stay put
        function void advance_generation();
            row_t snap [MAX_HEIGHT];
            int   w;
            int   h;
            int   n;
            int   rr;
            int   cc;
            snap = cells;
            w = used_width();
            h = used_height();
            for (int r = 0; r < h; r++) begin
                for (int c = 0; c < w; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
                                n += snap[rr][cc];
                        end
                    end
                    if (snap[r][c])
                        cells[r][c] = (n == 2 || n == 3);
                    else
                        cells[r][c] = (n == 3);
                end
            end
        endfunction

        function void note_command(life_cmd_t cmd);
            life_resp_t resp;
            resp.status     = 1'b0;
            resp.cell_alive = 1'b0;
            case (cmd.action)
                ACT_WRITE, ACT_READ: begin
                    if (cmd.column >= used_width() || cmd.row >= used_height())
                        resp.status = 1'b1;
                    else if (cmd.action == ACT_WRITE)
                        cells[cmd.row][cmd.column] = cmd.cell_value;
                    else
                        resp.cell_alive = cells[cmd.row][cmd.column];
                end
                ACT_STEP: advance_generation();
                default: ;
            endcase
            awaited.push_back(resp);
        endfunction

        function void check_response(logic status, logic cell_alive);
            life_resp_t exp_resp;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected response, expected none, got status %0b alive %0b",
                         $time, status, cell_alive);
                mismatches++;
                return;
            end
            exp_resp = awaited.pop_front();
            if (status !== exp_resp.status) begin
                $display("%0t: status mismatch, expected %0b, got %0b",
                         $time, exp_resp.status, status);
                mismatches++;
            end
            if (cell_alive !== exp_resp.cell_alive) begin
                $display("%0t: cell_alive mismatch, expected %0b, got %0b",
                         $time, exp_resp.cell_alive, cell_alive);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [1:0] action, [7:2] column, [13:8] row, [14] cell_value, [15] zero
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [0] status, [1] cell_alive, [7:2] zero
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    life_grid_model board = new();

    // idle-burst enables, changed per phase; both off for the tail
    bit tx_bursts = 1'b0;
    bit rx_bursts = 1'b0;
    int quiet_cycles = 0;

    life_grid_generation_step_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Response side: every accepted transaction is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_response(m_tdata[0], m_tdata[1]);
    end

    // Hang detection: any handshake on either stream or the APB port counts as progress.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("life_grid_generation_step_top test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver backpressure: random stall bursts.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_bursts && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 18);
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high, so back-to-back transactions need no gap.
    task automatic send_command(action_t action, int column, int row, bit cell_value);
        life_cmd_t cmd;
        cmd.action     = action;
        cmd.column     = column[COL_W-1:0];
        cmd.row        = row[ROWF_W-1:0];
        cmd.cell_value = cell_value;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_command(cmd);
        @(negedge clk);
    endtask

    task automatic maybe_pause();
        int gap;
        if (tx_bursts && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the sender until the block owes nothing, then let it settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup then access; register takes the value when pready is seen.
    task automatic configure(logic reg_sel, int value);
        logic [PDATA_W-1:0] word;
        wait_drained();
        word = $urandom();
        word[CFG_W-1:0] = value[CFG_W-1:0];
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(reg_sel, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly in-grid traffic seeded with live cells; a tenth goes anywhere.
    task automatic send_random(int w, int h);
        int      pick;
        int      column;
        int      row;
        action_t action;
        pick = $urandom_range(0, 99);
        if (w > 0 && h > 0 && $urandom_range(0, 9) != 0) begin
            column = $urandom_range(0, w - 1);
            row    = $urandom_range(0, h - 1);
        end
        else begin
            column = $urandom_range(0, 63);
            row    = $urandom_range(0, 63);
        end
        if (pick < 38)
            action = ACT_WRITE;
        else if (pick < 72)
            action = ACT_READ;
        else if (pick < 93)
            action = ACT_STEP;
        else
            action = ACT_UNUSED;
        maybe_pause();
        send_command(action, column, row, $urandom_range(0, 2) != 0);
    endtask

    initial
    begin
        int phase_w [11];
        int phase_h [11];
        int w;
        int h;
        phase_w = '{8, 1, 0, 9, 127, 64, 3, 2, 70, 16, 64};
        phase_h = '{8, 1, 9, 0, 127, 3, 64, 5, 6, 16, 64};
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: corners of the full grid, a blinker, the unused action.
        send_command(ACT_READ, 0, 0, 1'b0);
        send_command(ACT_WRITE, 0, 0, 1'b1);
        send_command(ACT_WRITE, 63, 63, 1'b1);
        send_command(ACT_WRITE, 63, 0, 1'b1);
        send_command(ACT_WRITE, 0, 63, 1'b1);
        for (int c = 10; c <= 12; c++)
            send_command(ACT_WRITE, c, 20, 1'b1);
        send_command(ACT_READ, 63, 63, 1'b0);
        send_command(ACT_UNUSED, 63, 63, 1'b1);
        send_command(ACT_STEP, 0, 0, 1'b0);
        send_command(ACT_READ, 11, 19, 1'b0);
        send_command(ACT_READ, 10, 20, 1'b0);
        send_command(ACT_READ, 0, 0, 1'b0);

        // Tiny grid: out-of-grid accesses; the blinker outside must survive.
        configure(REG_GRID_WIDTH, 3);
        configure(REG_GRID_HEIGHT, 2);
        send_command(ACT_WRITE, 3, 0, 1'b1);
        send_command(ACT_READ, 0, 2, 1'b0);
        send_command(ACT_WRITE, 1, 1, 1'b1);
        send_command(ACT_STEP, 0, 0, 1'b0);
        send_command(ACT_READ, 1, 1, 1'b0);

        // Zero width: every access is out of range, a step is a no-op.
        configure(REG_GRID_WIDTH, 0);
        send_command(ACT_WRITE, 0, 0, 1'b1);
        send_command(ACT_STEP, 0, 0, 1'b0);

        // Registers above the bound clamp to the full grid.
        configure(REG_GRID_WIDTH, 127);
        configure(REG_GRID_HEIGHT, 100);
        send_command(ACT_READ, 11, 21, 1'b0);
        send_command(ACT_READ, 63, 63, 1'b0);

        // Random phases over a spread of grid shapes.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 11) begin
                w = phase_w[p];
                h = phase_h[p];
            end
            else begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
            end
            configure(REG_GRID_WIDTH, w);
            configure(REG_GRID_HEIGHT, h);
            if (p >= PHASES - CALM_PHASES) begin
                tx_bursts = 1'b0;
                rx_bursts = 1'b0;
            end
            else begin
                tx_bursts = $urandom_range(0, 3) != 0;
                rx_bursts = $urandom_range(0, 3) != 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // one mid-phase pause with the pipe fully drained
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_random(board.used_width(), board.used_height());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("life_grid_generation_step_top test passed");
        else
            $display("life_grid_generation_step_top test failed");
        $finish;
    end

endmodule
